### src/pbws_pkg.sv
package pbws_pkg;

  // Field widths
  localparam int WORD_W = 32;
  localparam int KIND_W = 3;
  localparam int IDX_W  = 9;
  localparam int NIB_W  = 4;

  // Operation kinds
  localparam logic [KIND_W-1:0] KIND_WRITE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_UP    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DOWN  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LEFT  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_RIGHT = 3'd5;
  localparam logic [KIND_W-1:0] KIND_FLIP  = 3'd6;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  word_index;
    logic [WORD_W-1:0] write_word;
  } pbws_in_t;

  typedef struct packed {
    logic [WORD_W-1:0] read_word;
    logic [KIND_W-1:0] done_kind;
  } pbws_out_t;

  // Position flags of an address walker
  typedef struct packed {
    logic first;  // word 0 of its row
    logic last;   // last word of its row
    logic skip;   // flip: first visit of a pair's first row, no write
  } walk_stat_t;

endpackage

### src/packed_bitmap_wrap_scroll_flip.sv
// Channel   Ports                             Moves
// input     in_valid, in_ready, in_data       one request transaction (pbws_in_t)
// result    out_valid, out_ready, out_data    one result transaction (pbws_out_t)
//
// Word write or read passes through the word and finish states; unused kind 7
// goes straight to the finish state. Scroll up, down, left, right pass every
// word through the single read and single write memory port, one word each;
// flip reads each row pair as first row, second row, first row again.
// After reset a clearing pass writes zero to every word with in_ready low.
// A stalled result waits in the output register while the next request is
// taken; it finishes once that drains.
module packed_bitmap_wrap_scroll_flip #(
  parameter int ROWS          = 64,
  parameter int WORDS_PER_ROW = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pbws_pkg::pbws_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pbws_pkg::pbws_out_t out_data
);
  import pbws_pkg::*;

  localparam int WPR     = WORDS_PER_ROW;
  localparam int N       = ROWS * WPR;
  localparam int FLIP_N  = 3 * (ROWS / 2) * WPR;
  localparam int AW      = $clog2(N);
  localparam int CNT_W   = $clog2(((FLIP_N > N) ? FLIP_N : N) + 1);
  localparam int LAG_MAX = WPR + 1;
  localparam int LW      = $clog2(LAG_MAX + 1);
  localparam int NXT_TAP = (WPR >= 2) ? WPR - 2 : 0;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_WORD  = 3'd2;
  localparam logic [2:0] ST_RUN   = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [WORD_W-1:0] wword_r, wword_nxt;
  logic              inrange_r, inrange_nxt;
  logic [AW-1:0]     clr_addr_r, clr_addr_nxt;
  logic [CNT_W-1:0]  rd_left_r, rd_left_nxt;
  logic [CNT_W-1:0]  wr_left_r, wr_left_nxt;
  logic [LW-1:0]     lag_r, lag_nxt;
  logic              out_valid_r, out_valid_nxt;
  pbws_out_t         out_data_r, out_data_nxt;
  logic [WORD_W-1:0] dline_r [WPR];

  logic              acc;
  logic              rd_go, wr_go;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_wdata, mem_rdata;
  logic [AW-1:0]     rd_addr, wr_addr;
  walk_stat_t        wr_stat;
  logic [WORD_W-1:0] xf_data;
  logic              wr_ahead;

  assign acc      = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign rd_go    = (state_r == ST_RUN) && (rd_left_r != '0);
  assign wr_go    = (state_r == ST_RUN) && (lag_r == LW'(LAG_MAX)) && (wr_left_r != '0);
  assign wr_ahead = !(in_data.kind inside {KIND_LEFT, KIND_RIGHT});

  // Canvas store
  pbws_mem #(.DEPTH(N), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Read side walks the source order
  pbws_walk #(.ROWS(ROWS), .WORDS_PER_ROW(WPR), .AW(AW)) u_rd_walk (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (acc),
    .start_kind (in_data.kind),
    .ahead      (1'b0),
    .step       (rd_go),
    .addr       (rd_addr),
    .stat       ()
  );

  // Write side runs one row chunk ahead for up and down, one phase ahead for flip
  pbws_walk #(.ROWS(ROWS), .WORDS_PER_ROW(WPR), .AW(AW)) u_wr_walk (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (acc),
    .start_kind (in_data.kind),
    .ahead      (wr_ahead),
    .step       (wr_go),
    .addr       (wr_addr),
    .stat       (wr_stat)
  );

  // Pixel shift unit on the delayed word
  pbws_xform u_xform (
    .clk   (clk),
    .kind  (kind_r),
    .adv   (wr_go),
    .stat  (wr_stat),
    .cur   (dline_r[WPR-1]),
    .nxt   (dline_r[NXT_TAP]),
    .far   (dline_r[0]),
    .wdata (xf_data)
  );

  // One row of read data delay between read and write streams
  always_ff @(posedge clk) begin
    if (state_r == ST_RUN) begin
      dline_r[0] <= mem_rdata;
      for (int i = 1; i < WPR; i++) begin
        dline_r[i] <= dline_r[i-1];
      end
    end
  end

  // Memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_addr;
    mem_wdata = xf_data;
    mem_re    = 1'b0;
    mem_raddr = rd_addr;
    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
        mem_wdata = '0;
      end
      ST_WORD: begin
        mem_we    = (kind_r == KIND_WRITE) && inrange_r;
        mem_waddr = AW'(idx_r);
        mem_wdata = wword_r;
        mem_re    = (kind_r == KIND_READ) && inrange_r;
        mem_raddr = AW'(idx_r);
      end
      ST_RUN: begin
        mem_we = wr_go && !wr_stat.skip;
        mem_re = rd_go;
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    idx_nxt       = idx_r;
    wword_nxt     = wword_r;
    inrange_nxt   = inrange_r;
    clr_addr_nxt  = clr_addr_r;
    rd_left_nxt   = rd_left_r;
    wr_left_nxt   = wr_left_r;
    lag_nxt       = lag_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(N - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (acc) begin
          kind_nxt    = in_data.kind;
          idx_nxt     = in_data.word_index;
          wword_nxt   = in_data.write_word;
          inrange_nxt = (32'(in_data.word_index) < 32'(N));
          rd_left_nxt = (in_data.kind == KIND_FLIP) ? CNT_W'(FLIP_N) : CNT_W'(N);
          wr_left_nxt = (in_data.kind == KIND_FLIP) ? CNT_W'(FLIP_N) : CNT_W'(N);
          lag_nxt     = '0;
          case (in_data.kind)
            KIND_WRITE, KIND_READ: state_nxt = ST_WORD;
            KIND_UP, KIND_DOWN, KIND_LEFT, KIND_RIGHT, KIND_FLIP: state_nxt = ST_RUN;
            default: state_nxt = ST_FIN;
          endcase
        end
      end
      ST_WORD: begin
        state_nxt = ST_FIN;
      end
      ST_RUN: begin
        rd_left_nxt = rd_left_r - CNT_W'(rd_go);
        wr_left_nxt = wr_left_r - CNT_W'(wr_go);
        if (lag_r != LW'(LAG_MAX)) begin
          lag_nxt = lag_r + LW'(1);
        end
        if (wr_go && (wr_left_r == CNT_W'(1))) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.read_word = ((kind_r == KIND_READ) && inrange_r) ? mem_rdata : '0;
          out_data_nxt.done_kind = kind_r;
          state_nxt              = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      rd_left_r   <= '0;
      wr_left_r   <= '0;
      lag_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      rd_left_r   <= rd_left_nxt;
      wr_left_r   <= wr_left_nxt;
      lag_r       <= lag_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    idx_r      <= idx_nxt;
    wword_r    <= wword_nxt;
    inrange_r  <= inrange_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // The canvas is never written while waiting for a request
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !mem_we)
    else $error("canvas written while idle");

  // Reads never fall behind writes in a whole-canvas pass
  a_rd_ahead: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (rd_left_r <= wr_left_r))
    else $error("read stream behind write stream");

  // The last write of a pass comes after every read
  a_last_write: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_go && (wr_left_r == CNT_W'(1))) |-> (rd_left_r == '0))
    else $error("pass finished with reads outstanding");

  // A taken request moves the sequencer out of idle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> (state_r != ST_IDLE))
    else $error("request taken but sequencer still idle");
`endif

endmodule

### src/pbws_mem.sv
module pbws_mem #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [pbws_pkg::WORD_W-1:0] wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [pbws_pkg::WORD_W-1:0] rdata
);
  import pbws_pkg::*;

  logic [WORD_W-1:0] mem_r [DEPTH];
  logic [WORD_W-1:0] rdata_r;

  // One write and one registered read per cycle; a read returns the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/pbws_walk.sv
module pbws_walk #(
  parameter int ROWS          = 64,
  parameter int WORDS_PER_ROW = 8,
  parameter int AW            = $clog2(ROWS * WORDS_PER_ROW)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [pbws_pkg::KIND_W-1:0] start_kind,
  input  logic                        ahead,
  input  logic                        step,
  output logic [AW-1:0]               addr,
  output pbws_pkg::walk_stat_t        stat
);
  import pbws_pkg::*;

  localparam int CW = (WORDS_PER_ROW > 1) ? $clog2(WORDS_PER_ROW) : 1;
  localparam int KW = $clog2(ROWS + 1);
  localparam int RW = $clog2(ROWS);

  // Flip visits each row pair as first row, second row, first row again
  localparam logic [1:0] PH_A = 2'd0;
  localparam logic [1:0] PH_B = 2'd1;
  localparam logic [1:0] PH_C = 2'd2;

  logic [KIND_W-1:0] op_r, op_nxt;
  logic [CW-1:0]     c_r, c_nxt;
  logic [KW-1:0]     k_r, k_nxt;
  logic [1:0]        ph_r, ph_nxt;
  logic [RW-1:0]     row;
  logic              last_word;

  assign last_word = (c_r == CW'(WORDS_PER_ROW - 1));

  // Word and row-chunk counters
  always_comb begin
    op_nxt = op_r;
    c_nxt  = c_r;
    k_nxt  = k_r;
    ph_nxt = ph_r;
    if (start) begin
      op_nxt = start_kind;
      c_nxt  = '0;
      k_nxt  = '0;
      ph_nxt = PH_A;
      if (ahead) begin
        if (start_kind == KIND_FLIP) begin
          ph_nxt = PH_B;
        end else begin
          k_nxt = KW'(1);
        end
      end
    end else if (step) begin
      if (last_word) begin
        c_nxt = '0;
        if (op_r == KIND_FLIP) begin
          if (ph_r == PH_C) begin
            ph_nxt = PH_A;
            k_nxt  = k_r + KW'(1);
          end else begin
            ph_nxt = ph_r + 2'd1;
          end
        end else begin
          k_nxt = k_r + KW'(1);
        end
      end else begin
        c_nxt = c_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r <= KIND_WRITE;
      c_r  <= '0;
      k_r  <= '0;
      ph_r <= PH_A;
    end else begin
      op_r <= op_nxt;
      c_r  <= c_nxt;
      k_r  <= k_nxt;
      ph_r <= ph_nxt;
    end
  end

  // Chunk number to canvas row
  always_comb begin
    case (op_r)
      KIND_UP: begin
        row = (k_r == '0) ? '0 : RW'(KW'(ROWS) - k_r);
      end
      KIND_DOWN: begin
        row = (k_r == KW'(ROWS)) ? '0 : RW'(k_r);
      end
      KIND_FLIP: begin
        row = (ph_r == PH_B) ? RW'(KW'(ROWS - 1) - k_r) : RW'(k_r);
      end
      default: begin
        row = RW'(k_r);
      end
    endcase
  end

  assign addr       = AW'(row) * AW'(WORDS_PER_ROW) + AW'(c_r);
  assign stat.first = (c_r == '0);
  assign stat.last  = last_word;
  assign stat.skip  = (op_r == KIND_FLIP) && (ph_r == PH_A);

endmodule

### src/pbws_xform.sv
module pbws_xform (
  input  logic                        clk,
  input  logic [pbws_pkg::KIND_W-1:0] kind,
  input  logic                        adv,
  input  pbws_pkg::walk_stat_t        stat,
  input  logic [pbws_pkg::WORD_W-1:0] cur,
  input  logic [pbws_pkg::WORD_W-1:0] nxt,
  input  logic [pbws_pkg::WORD_W-1:0] far,
  output logic [pbws_pkg::WORD_W-1:0] wdata
);
  import pbws_pkg::*;

  logic [NIB_W-1:0] lo_r;   // leftmost pixel of the current row
  logic [NIB_W-1:0] hi_r;   // top pixel of the previous word
  logic [NIB_W-1:0] wrap_nib;

  // Nibble shift with the carry pixel from the neighbor word
  always_comb begin
    wrap_nib = '0;
    case (kind)
      KIND_LEFT: begin
        if (stat.last) begin
          wrap_nib = stat.first ? cur[NIB_W-1:0] : lo_r;
        end else begin
          wrap_nib = nxt[NIB_W-1:0];
        end
        wdata = (cur >> NIB_W) | {wrap_nib, {(WORD_W - NIB_W){1'b0}}};
      end
      KIND_RIGHT: begin
        wrap_nib = stat.first ? far[WORD_W-1 -: NIB_W] : hi_r;
        wdata    = (cur << NIB_W) | WORD_W'(wrap_nib);
      end
      default: begin
        wdata = cur;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hi_r <= cur[WORD_W-1 -: NIB_W];
      if (stat.first) begin
        lo_r <= cur[NIB_W-1:0];
      end
    end
  end

endmodule
